>>> src/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// bpfm_pkg: shared types and constants of the buffer pool frame manager
// Request and result payloads, frame table entry, function and status codes.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int unsigned POOL_FRAMES_DEF = 16;
  localparam logic [31:0] PAGE_NONE       = 32'hFFFF_FFFF;
  localparam logic [7:0]  PIN_MAX         = 8'hFF;

  // function codes
  localparam logic [2:0] FN_NEW    = 3'd0;
  localparam logic [2:0] FN_FETCH  = 3'd1;
  localparam logic [2:0] FN_UNPIN  = 3'd2;
  localparam logic [2:0] FN_DELETE = 3'd3;
  localparam logic [2:0] FN_FLUSH  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ABSENT   = 3'd1;
  localparam logic [2:0] ST_PINNED   = 3'd2;
  localparam logic [2:0] ST_UNPINNED = 3'd3;
  localparam logic [2:0] ST_NO_FRAME = 3'd4;

  // configuration register indexes
  localparam logic CFG_INST_COUNT = 1'b0;
  localparam logic CFG_INST_NUM   = 1'b1;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] page_id;
    logic               mark_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         frame_index;
    logic [30:0]        assigned_page;
    logic               writeback_valid;
    logic signed [31:0] writeback_page;
    logic               read_valid;
    logic               new_write_valid;
  } res_t;

  typedef struct packed {
    logic [31:0] page;
    logic [7:0]  pins;
    logic        dirty;
  } fent_t;

endpackage

>>> src/bpfm_frame_tbl.sv
// ----------------------------------------------------------------------------
// bpfm_frame_tbl: frame table memory
// Page id, pin count and dirty mark per frame; one write and one registered
// read per cycle. Frames never written read as empty.
// ----------------------------------------------------------------------------
module bpfm_frame_tbl #(
  parameter int unsigned POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF,
  localparam int unsigned FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [FW-1:0]   rd_addr,
  output bpfm_pkg::fent_t rd_ent,
  input  logic            wr_en,
  input  logic [FW-1:0]   wr_addr,
  input  bpfm_pkg::fent_t wr_ent
);

  bpfm_pkg::fent_t        mem [POOL_FRAMES];
  logic [POOL_FRAMES-1:0] vld_r;
  bpfm_pkg::fent_t        q_r;
  logic                   q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_ent = q_vld_r ? q_r
                          : bpfm_pkg::fent_t'{page: bpfm_pkg::PAGE_NONE, pins: 8'd0,
                                              dirty: 1'b0};

endmodule

>>> src/bpfm_lru_mem.sv
// ----------------------------------------------------------------------------
// bpfm_lru_mem: LRU order memory
// Frame numbers, oldest first; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpfm_lru_mem #(
  parameter int unsigned POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF,
  localparam int unsigned FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1
) (
  input  logic          clk,
  input  logic [FW-1:0] rd_addr,
  output logic [FW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [FW-1:0] wr_addr,
  input  logic [FW-1:0] wr_data
);

  logic [FW-1:0] mem [POOL_FRAMES];
  logic [FW-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  assign rd_data = q_r;

endmodule

>>> src/buffer_pool_frame_manager_unit.sv
// Sequence: the frame search reads, then compares, each frame in turn; an LRU search reads,
//   then compares, each entry, and an LRU shift reads, then writes, each entry.
// Throughput: one request at a time; busy stays high through the result cycle.
// Results show for exactly one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) empties the pool at once: no clearing pass.
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_unit: buffer pool frame manager with LRU
// Sequencer over frame table, free stack and LRU order, each a memory with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_unit #(
  parameter int unsigned POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bpfm_pkg::req_t in_req,
  output logic           out_valid,
  output bpfm_pkg::res_t out_res,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [4:0]     cfg_data
);

  localparam int unsigned FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int unsigned CW = $clog2(POOL_FRAMES + 1);
  localparam logic [CW-1:0] N_CNT = CW'(POOL_FRAMES);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_HIT, S_MISS, S_TAKE, S_TAKE_FS,
    S_TAKE_LRU, S_SH_RD, S_SH_WR, S_LS_RD, S_LS_CMP, S_VIC_RD, S_VIC_WR,
    S_PUSH, S_DONE
  } state_t;

  state_t state_r, state_nxt, after_r, after_nxt;
  bpfm_pkg::req_t req_r, req_nxt;
  bpfm_pkg::res_t res_r, res_nxt;
  logic [FW-1:0]  f_r, f_nxt;
  logic [CW-1:0]  scan_r, scan_nxt;
  logic [CW-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CW-1:0]  lru_cnt_r, lru_cnt_nxt;
  logic           ladd_r, ladd_nxt;       // LRU search appends when set, else removes
  logic [30:0]    next_page_r, next_page_nxt;
  logic [4:0]     icount_r;

  // frame table ports
  logic [FW-1:0]   frd_addr, fwr_addr;
  bpfm_pkg::fent_t frd_ent, fwr_ent;
  logic            fwr_en;

  // LRU ports
  logic [FW-1:0] lrd_addr, lrd_data, lwr_addr, lwr_data;
  logic          lwr_en;

  // free stack: entries never written hold their own frame number
  logic [FW-1:0]          fs_mem [POOL_FRAMES];
  logic [POOL_FRAMES-1:0] fs_vld_r;
  logic [FW-1:0]          fs_q_r, fs_rd_addr, fs_wr_addr;
  logic                   fs_q_vld_r, fs_wr_en;
  logic [FW-1:0]          fs_q_raw_r;

  bpfm_frame_tbl #(.POOL_FRAMES(POOL_FRAMES)) u_ftbl (
    .clk(clk), .rst_n(rst_n), .rd_addr(frd_addr), .rd_ent(frd_ent),
    .wr_en(fwr_en), .wr_addr(fwr_addr), .wr_ent(fwr_ent)
  );

  bpfm_lru_mem #(.POOL_FRAMES(POOL_FRAMES)) u_lru (
    .clk(clk), .rd_addr(lrd_addr), .rd_data(lrd_data),
    .wr_en(lwr_en), .wr_addr(lwr_addr), .wr_data(lwr_data)
  );

  always_ff @(posedge clk) begin
    if (fs_wr_en) begin
      fs_mem[fs_wr_addr] <= f_r;
    end
    fs_q_raw_r <= fs_mem[fs_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_vld_r   <= '0;
      fs_q_vld_r <= 1'b0;
      fs_q_r     <= '0;
    end else begin
      fs_q_vld_r <= fs_vld_r[fs_rd_addr];
      fs_q_r     <= fs_rd_addr;
      if (fs_wr_en) begin
        fs_vld_r[fs_wr_addr] <= 1'b1;
      end
    end
  end

  logic [FW-1:0] fs_top;
  assign fs_top = fs_q_vld_r ? fs_q_raw_r : fs_q_r;

  // read addresses
  logic [CW-1:0] free_dec;
  assign free_dec   = free_cnt_r - CW'(1);
  assign fs_rd_addr = free_dec[FW-1:0];
  assign frd_addr   = (state_r == S_VIC_RD) ? f_r : scan_r[FW-1:0];
  assign lrd_addr   = (state_r == S_TAKE) ? '0 : scan_r[FW-1:0];

  logic [31:0] pid_u;
  assign pid_u = $unsigned(req_r.page_id);

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    f_nxt         = f_r;
    scan_nxt      = scan_r;
    free_cnt_nxt  = free_cnt_r;
    lru_cnt_nxt   = lru_cnt_r;
    ladd_nxt      = ladd_r;
    next_page_nxt = next_page_r;
    fwr_en        = 1'b0;
    fwr_addr      = f_r;
    fwr_ent       = frd_ent;
    lwr_en        = 1'b0;
    lwr_addr      = lru_cnt_r[FW-1:0];
    lwr_data      = f_r;
    fs_wr_en      = 1'b0;
    fs_wr_addr    = free_cnt_r[FW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_req;
          scan_nxt = '0;
          res_nxt  = '{status: bpfm_pkg::ST_OK, frame_index: 4'd0, assigned_page: 31'd0,
                       writeback_valid: 1'b0, writeback_page: bpfm_pkg::PAGE_NONE,
                       read_valid: 1'b0, new_write_valid: 1'b0};
          if (in_req.func == bpfm_pkg::FN_NEW) begin
            state_nxt = S_TAKE;
          end else if (in_req.func > bpfm_pkg::FN_FLUSH ||
                       $unsigned(in_req.page_id) == bpfm_pkg::PAGE_NONE) begin
            res_nxt.status = bpfm_pkg::ST_ABSENT;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FIND_RD;
          end
        end
      end

      S_FIND_RD: state_nxt = S_FIND_CMP;

      S_FIND_CMP: begin
        if (frd_ent.page == pid_u) begin
          f_nxt     = scan_r[FW-1:0];
          state_nxt = S_HIT;
        end else if (scan_r == N_CNT - CW'(1)) begin
          state_nxt = S_MISS;
        end else begin
          scan_nxt  = scan_r + CW'(1);
          state_nxt = S_FIND_RD;
        end
      end

      S_HIT: begin
        // frd_ent still holds the matching entry
        res_nxt.frame_index = 4'(f_r);
        scan_nxt            = '0;
        ladd_nxt            = 1'b0;
        after_nxt           = S_DONE;
        state_nxt           = S_DONE;
        case (req_r.func)
          bpfm_pkg::FN_FETCH: begin
            fwr_en = 1'b1;
            if (frd_ent.pins != bpfm_pkg::PIN_MAX) begin
              fwr_ent.pins = frd_ent.pins + 8'd1;
            end
            state_nxt = S_LS_RD;
          end
          bpfm_pkg::FN_UNPIN: begin
            if (frd_ent.pins == 8'd0) begin
              res_nxt.status = bpfm_pkg::ST_UNPINNED;
            end else begin
              fwr_en        = 1'b1;
              fwr_ent.pins  = frd_ent.pins - 8'd1;
              fwr_ent.dirty = frd_ent.dirty | req_r.mark_dirty;
              if (frd_ent.pins == 8'd1) begin
                ladd_nxt  = 1'b1;
                state_nxt = S_LS_RD;
              end
            end
          end
          bpfm_pkg::FN_DELETE: begin
            if (frd_ent.pins != 8'd0) begin
              res_nxt.status = bpfm_pkg::ST_PINNED;
            end else begin
              if (frd_ent.dirty) begin
                res_nxt.writeback_valid = 1'b1;
                res_nxt.writeback_page  = $signed(frd_ent.page);
              end
              fwr_en    = 1'b1;
              fwr_ent   = '{page: bpfm_pkg::PAGE_NONE, pins: 8'd0, dirty: 1'b0};
              after_nxt = S_PUSH;
              state_nxt = S_LS_RD;
            end
          end
          default: begin // flush
            res_nxt.writeback_valid = 1'b1;
            res_nxt.writeback_page  = req_r.page_id;
            fwr_en                  = 1'b1;
            fwr_ent.dirty           = 1'b0;
          end
        endcase
      end

      S_MISS: begin
        if (req_r.func == bpfm_pkg::FN_FETCH) begin
          state_nxt = S_TAKE;
        end else begin
          res_nxt.status = bpfm_pkg::ST_ABSENT;
          state_nxt      = S_DONE;
        end
      end

      S_TAKE: begin
        if (free_cnt_r != '0) begin
          free_cnt_nxt = free_dec;
          state_nxt    = S_TAKE_FS;
        end else if (lru_cnt_r != '0) begin
          state_nxt = S_TAKE_LRU;
        end else begin
          res_nxt.status = bpfm_pkg::ST_NO_FRAME;
          state_nxt      = S_DONE;
        end
      end

      S_TAKE_FS: begin
        f_nxt     = fs_top;
        state_nxt = S_VIC_RD;
      end

      S_TAKE_LRU: begin
        f_nxt     = lrd_data;
        scan_nxt  = CW'(1);
        after_nxt = S_VIC_RD;
        state_nxt = S_SH_RD;
      end

      // close the gap: entry j moves to j-1
      S_SH_RD: begin
        if (scan_r >= lru_cnt_r) begin
          lru_cnt_nxt = lru_cnt_r - CW'(1);
          state_nxt   = after_r;
        end else begin
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        lwr_en    = 1'b1;
        lwr_addr  = FW'(scan_r - CW'(1));
        lwr_data  = lrd_data;
        scan_nxt  = scan_r + CW'(1);
        state_nxt = S_SH_RD;
      end

      S_LS_RD: begin
        if (scan_r >= lru_cnt_r) begin
          if (ladd_r && lru_cnt_r < N_CNT) begin
            lwr_en      = 1'b1;
            lru_cnt_nxt = lru_cnt_r + CW'(1);
          end
          state_nxt = after_r;
        end else begin
          state_nxt = S_LS_CMP;
        end
      end

      S_LS_CMP: begin
        scan_nxt = scan_r + CW'(1);
        if (lrd_data == f_r) begin
          state_nxt = ladd_r ? after_r : S_SH_RD;
        end else begin
          state_nxt = S_LS_RD;
        end
      end

      S_VIC_RD: state_nxt = S_VIC_WR;

      S_VIC_WR: begin
        if (frd_ent.dirty && frd_ent.page != bpfm_pkg::PAGE_NONE) begin
          res_nxt.writeback_valid = 1'b1;
          res_nxt.writeback_page  = $signed(frd_ent.page);
        end
        res_nxt.frame_index = 4'(f_r);
        fwr_en              = 1'b1;
        fwr_ent.pins        = 8'd1;
        fwr_ent.dirty       = 1'b0;
        if (req_r.func == bpfm_pkg::FN_NEW) begin
          fwr_ent.page            = {1'b0, next_page_r};
          res_nxt.assigned_page   = next_page_r;
          res_nxt.new_write_valid = 1'b1;
          next_page_nxt           = next_page_r + 31'(icount_r);
        end else begin
          fwr_ent.page       = pid_u;
          res_nxt.read_valid = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_PUSH: begin
        if (free_cnt_r < N_CNT) begin
          fs_wr_en     = 1'b1;
          free_cnt_nxt = free_cnt_r + CW'(1);
        end
        state_nxt = S_DONE;
      end

      S_DONE: state_nxt = S_IDLE;

      default: state_nxt = S_IDLE;
    endcase

    // instance number write restarts page id allocation (user: only while idle, unenforced)
    if (cfg_we && cfg_index == bpfm_pkg::CFG_INST_NUM) begin
      next_page_nxt = 31'(cfg_data[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_DONE;
      free_cnt_r  <= N_CNT;
      lru_cnt_r   <= '0;
      next_page_r <= '0;
      icount_r    <= 5'd1;
      ladd_r      <= 1'b0;
      scan_r      <= '0;
      req_r       <= '0;
      res_r       <= '0;
      f_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      free_cnt_r  <= free_cnt_nxt;
      lru_cnt_r   <= lru_cnt_nxt;
      next_page_r <= next_page_nxt;
      ladd_r      <= ladd_nxt;
      scan_r      <= scan_nxt;
      req_r       <= req_nxt;
      res_r       <= res_nxt;
      f_r         <= f_nxt;
      if (cfg_we && cfg_index == bpfm_pkg::CFG_INST_COUNT) begin
        icount_r <= cfg_data;
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_res   = res_r;

  logic [CW:0] occ;
  assign occ = {1'b0, free_cnt_r} + {1'b0, lru_cnt_r};

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= N_CNT) else $error("free count beyond pool size");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= (CW+1)'(POOL_FRAMES)) else $error("free plus LRU frames beyond pool size");

  a_one_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result held longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");

endmodule
